@@ hw/rtl/lru_key_value_cache_assert.svh @@
// Assertion macros shared by the cache modules.
// Each macro expects signals named clk and rst_n in the module that uses it.
`ifndef LRU_KEY_VALUE_CACHE_ASSERT_SVH
`define LRU_KEY_VALUE_CACHE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LKVC_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lkvc assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define LKVC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lkvc assertion failed");

`endif

@@ hw/rtl/lkvc_pkg.sv @@
`default_nettype none

package lkvc_pkg;

    localparam int unsigned WORD_W = 32;
    localparam int unsigned CAP_W  = 5;

    localparam logic [CAP_W-1:0]  CAP_RESET  = 5'd16;
    localparam logic [WORD_W-1:0] MISS_VALUE = 32'hFFFF_FFFF;

    localparam logic OP_LOOKUP = 1'b0;
    localparam logic OP_WRITE  = 1'b1;

    typedef struct packed {
        logic                     operation;
        logic signed [WORD_W-1:0] key;
        logic signed [WORD_W-1:0] value;
    } in_word_t;

    typedef struct packed {
        logic                     hit;
        logic signed [WORD_W-1:0] data_value;
        logic                     evicted;
        logic signed [WORD_W-1:0] evicted_key;
    } out_word_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic search;
        logic decide;
        logic update;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic sweep_last;
        logic need_update;
    } status_t;

endpackage

`default_nettype wire

@@ hw/rtl/lkvc_ram.sv @@
`default_nettype none

module lkvc_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 16
) (
    input  wire logic                                   clk,
    input  wire logic                                   we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                       wdata,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

@@ hw/rtl/lkvc_ctrl.sv @@
`default_nettype none
`include "lru_key_value_cache_assert.svh"

module lkvc_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    output logic                   busy,
    output lkvc_pkg::cmd_t         cmd,
    input  wire lkvc_pkg::status_t status
);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_SEARCH = 4'b0010,
        ST_DECIDE = 4'b0100,
        ST_UPDATE = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_SEARCH;
                end
            end
            ST_SEARCH:
            begin
                cmd.search = 1'b1;
                if (status.sweep_last)
                begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                cmd.decide = 1'b1;
                state_next = status.need_update ? ST_UPDATE : ST_IDLE;
            end
            ST_UPDATE:
            begin
                cmd.update = 1'b1;
                if (status.sweep_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != ST_IDLE);

    // An accepted word always starts a search on the next cycle.
    `LKVC_ASSERT_NEXT(a_accept_to_search, start && !busy, state_reg == ST_SEARCH)
    // The search ends in the decision cycle once the last entry has been compared.
    `LKVC_ASSERT_NEXT(a_search_to_decide, state_reg == ST_SEARCH && status.sweep_last,
                      state_reg == ST_DECIDE)

endmodule

`default_nettype wire

@@ hw/rtl/lkvc_datapath.sv @@
`default_nettype none
`include "lru_key_value_cache_assert.svh"

module lkvc_datapath #(
    parameter int unsigned MAX_ENTRIES = 16
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire lkvc_pkg::in_word_t                in_word,
    input  wire logic                              cfg_we,
    input  wire logic [lkvc_pkg::CAP_W-1:0]        cfg_wdata,
    input  wire lkvc_pkg::cmd_t                    cmd,
    output lkvc_pkg::status_t                      status,
    output logic                                   result_valid,
    output lkvc_pkg::out_word_t                    result
);

    localparam int unsigned IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int unsigned CNT_W = $clog2(MAX_ENTRIES + 1);
    localparam int unsigned EFF_W = (CNT_W > lkvc_pkg::CAP_W) ? CNT_W : lkvc_pkg::CAP_W;
    localparam int unsigned WW    = lkvc_pkg::WORD_W;

    // Control state.
    logic [lkvc_pkg::CAP_W-1:0] cap_reg;
    logic [CNT_W-1:0]           count_reg, count_next;
    logic [MAX_ENTRIES-1:0]     valid_reg, valid_next;
    logic [CNT_W-1:0]           cnt_reg, cnt_next;
    logic                       rd_vld_reg, rd_vld_next;
    logic                       strobe_reg;

    // Payload state.
    lkvc_pkg::in_word_t  in_reg;
    logic [IDX_W-1:0]    rd_idx_reg;
    logic                found_reg;
    logic [IDX_W-1:0]    hit_idx_reg;
    logic [IDX_W-1:0]    hit_rank_reg;
    logic [WW-1:0]       hit_value_reg;
    logic                lru_found_reg;
    logic [IDX_W-1:0]    lru_idx_reg;
    logic [WW-1:0]       lru_key_reg;
    logic                free_found_reg;
    logic [IDX_W-1:0]    free_idx_reg;
    logic [IDX_W-1:0]    target_reg;
    logic [IDX_W-1:0]    thr_reg;
    logic                all_reg;
    lkvc_pkg::out_word_t out_reg;

    // Memory ports.
    logic [IDX_W-1:0] raddr;
    logic [WW-1:0]    key_q, value_q;
    logic [IDX_W-1:0] rank_q;
    logic             key_we, value_we, rank_we;
    logic [IDX_W-1:0] wr_idx;
    logic [IDX_W-1:0] rank_wdata;

    // Decision terms.
    logic             is_write;
    logic             sweeping;
    logic             entry_valid;
    logic             key_match;
    logic             lru_match;
    logic [CNT_W-1:0] count_m1;
    logic [EFF_W-1:0] cap_e, eff_cap;
    logic             full;
    logic             do_evict;
    logic             do_insert;
    logic [IDX_W-1:0] slot;
    logic             is_target;
    logic             rank_bump;

    assign raddr = (cnt_reg < CNT_W'(MAX_ENTRIES)) ? cnt_reg[IDX_W-1:0] : '0;

    lkvc_ram #(.WIDTH(WW), .DEPTH(MAX_ENTRIES)) u_key_ram (
        .clk   (clk),
        .we    (key_we),
        .waddr (wr_idx),
        .wdata (in_reg.key),
        .raddr (raddr),
        .rdata (key_q)
    );

    lkvc_ram #(.WIDTH(WW), .DEPTH(MAX_ENTRIES)) u_value_ram (
        .clk   (clk),
        .we    (value_we),
        .waddr (wr_idx),
        .wdata (in_reg.value),
        .raddr (raddr),
        .rdata (value_q)
    );

    lkvc_ram #(.WIDTH(IDX_W), .DEPTH(MAX_ENTRIES)) u_rank_ram (
        .clk   (clk),
        .we    (rank_we),
        .waddr (cmd.update ? rd_idx_reg : wr_idx),
        .wdata (rank_wdata),
        .raddr (raddr),
        .rdata (rank_q)
    );

    assign is_write    = (in_reg.operation == lkvc_pkg::OP_WRITE);
    assign sweeping    = cmd.search || cmd.update;
    assign entry_valid = valid_reg[rd_idx_reg];
    assign count_m1    = count_reg - CNT_W'(1);
    assign key_match   = rd_vld_reg && entry_valid && (key_q == in_reg.key);
    assign lru_match   = rd_vld_reg && entry_valid && (CNT_W'(rank_q) == count_m1);

    // A capacity of zero acts as one; anything above the table size saturates.
    assign cap_e   = EFF_W'(cap_reg);
    assign eff_cap = (cap_reg == '0) ? EFF_W'(1)
                   : ((cap_e > EFF_W'(MAX_ENTRIES)) ? EFF_W'(MAX_ENTRIES) : cap_e);
    assign full    = (EFF_W'(count_reg) >= eff_cap) && (count_reg != '0);

    assign do_evict  = is_write && !found_reg && full && lru_found_reg;
    assign do_insert = is_write && !found_reg && (do_evict || free_found_reg);

    // The new entry goes to the lowest free slot, counting the one just evicted.
    always_comb
    begin
        if (do_evict)
        begin
            slot = (free_found_reg && (free_idx_reg < lru_idx_reg)) ? free_idx_reg
                                                                     : lru_idx_reg;
        end
        else
        begin
            slot = free_idx_reg;
        end
    end

    assign wr_idx   = found_reg ? hit_idx_reg : slot;
    assign key_we   = cmd.decide && do_insert;
    assign value_we = cmd.decide && is_write && (found_reg || do_insert);

    assign is_target  = (rd_idx_reg == target_reg);
    assign rank_bump  = entry_valid && (all_reg || (rank_q < thr_reg));
    assign rank_we    = cmd.update && rd_vld_reg && (is_target || rank_bump);
    assign rank_wdata = is_target ? '0 : (rank_q + IDX_W'(1));

    assign status.sweep_last  = (cnt_reg == CNT_W'(MAX_ENTRIES));
    assign status.need_update = found_reg || do_insert;

    always_comb
    begin
        cnt_next    = cnt_reg;
        rd_vld_next = 1'b0;
        if (cmd.load || cmd.decide)
        begin
            cnt_next = '0;
        end
        else if (sweeping && (cnt_reg < CNT_W'(MAX_ENTRIES)))
        begin
            cnt_next    = cnt_reg + CNT_W'(1);
            rd_vld_next = 1'b1;
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        count_next = count_reg;
        if (cmd.decide)
        begin
            if (do_evict)
            begin
                valid_next[lru_idx_reg] = 1'b0;
            end
            if (do_insert)
            begin
                valid_next[slot] = 1'b1;
            end
            count_next = count_reg - CNT_W'(do_evict) + CNT_W'(do_insert);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg    <= lkvc_pkg::CAP_RESET;
            count_reg  <= '0;
            valid_reg  <= '0;
            cnt_reg    <= '0;
            rd_vld_reg <= 1'b0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                cap_reg <= cfg_wdata;
            end
            count_reg  <= count_next;
            valid_reg  <= valid_next;
            cnt_reg    <= cnt_next;
            rd_vld_reg <= rd_vld_next;
            strobe_reg <= cmd.decide;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_idx_reg <= raddr;
        if (cmd.load)
        begin
            in_reg         <= in_word;
            found_reg      <= 1'b0;
            lru_found_reg  <= 1'b0;
            free_found_reg <= 1'b0;
        end
        if (cmd.search)
        begin
            if (key_match && !found_reg)
            begin
                found_reg     <= 1'b1;
                hit_idx_reg   <= rd_idx_reg;
                hit_rank_reg  <= rank_q;
                hit_value_reg <= value_q;
            end
            if (lru_match && !lru_found_reg)
            begin
                lru_found_reg <= 1'b1;
                lru_idx_reg   <= rd_idx_reg;
                lru_key_reg   <= key_q;
            end
            if (rd_vld_reg && !entry_valid && !free_found_reg)
            begin
                free_found_reg <= 1'b1;
                free_idx_reg   <= rd_idx_reg;
            end
        end
        if (cmd.decide)
        begin
            target_reg          <= wr_idx;
            thr_reg             <= hit_rank_reg;
            all_reg             <= !found_reg;
            out_reg.hit         <= found_reg;
            out_reg.data_value  <= is_write ? in_reg.value
                                 : (found_reg ? hit_value_reg : lkvc_pkg::MISS_VALUE);
            out_reg.evicted     <= do_evict;
            out_reg.evicted_key <= do_evict ? lru_key_reg : '0;
        end
    end

    assign result_valid = strobe_reg;
    assign result       = out_reg;

    // The fill count always agrees with the number of valid entries.
    `LKVC_ASSERT_NOW(a_count_matches_valid, 1'b1, $countones(valid_reg) == count_reg)
    // Each word gives exactly one result strobe.
    `LKVC_ASSERT_NEXT(a_single_strobe, strobe_reg, !strobe_reg)

endmodule

`default_nettype wire

@@ hw/rtl/lru_key_value_cache.sv @@
// An accepted word runs a key-compare sweep of the entry memories, then the decide state,
// from which the result strobe is registered. A lookup miss ends there; a hit or a write
// then runs a rank-update sweep. Each sweep visits one entry per cycle, and no new word is
// taken until the cache is idle again. The receiver cannot stall the result strobe.
// Reset (rst_n, asynchronous, active low) empties the cache at once and sets capacity to 16.
`default_nettype none

// Fully associative key/value cache with least-recently-used replacement.
//
// Keys, values and recency ranks live in three small RAMs of MAX_ENTRIES words with
// registered reads. The valid bits and the fill count are flip-flops, so the stored
// contents need no clearing after reset: an entry is only looked at while it is valid.
//
// Each accepted word runs through these steps:
//   search  - every entry is read in turn; the first valid key match, the valid entry
//             whose rank is the oldest, and the lowest free slot are recorded.
//   decide  - the result word is formed, values and keys are written, an eviction and
//             an insertion update the valid bits and the fill count.
//   update  - on a hit or an insertion, the ranks are swept once more: entries more
//             recent than the touched one (or all valid ones on an insertion) age by
//             one and the touched entry becomes rank zero.
// A lookup miss changes nothing and skips the update sweep.
//
// The capacity register may be written at any cycle the block is idle. A value of zero
// acts as one and a value above MAX_ENTRIES acts as MAX_ENTRIES. Lowering it below the
// current fill does not flush anything: each new key then evicts exactly one old entry.

module lru_key_value_cache #(
    parameter int unsigned MAX_ENTRIES = 16
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    output logic                            busy,
    input  wire lkvc_pkg::in_word_t         in_word,
    input  wire logic                       cfg_we,
    input  wire logic [lkvc_pkg::CAP_W-1:0] cfg_wdata,
    output logic                            result_valid,
    output lkvc_pkg::out_word_t             result
);

    lkvc_pkg::cmd_t    cmd;
    lkvc_pkg::status_t status;

    // The sequencer owns the handshake and steps the datapath through the phases.
    lkvc_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .cmd    (cmd),
        .status (status)
    );

    // The datapath holds the entry memories, the capacity register and the result word.
    lkvc_datapath #(.MAX_ENTRIES(MAX_ENTRIES)) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_word      (in_word),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .cmd          (cmd),
        .status       (status),
        .result_valid (result_valid),
        .result       (result)
    );

endmodule

`default_nettype wire

@@ verif/tb.sv @@
`default_nettype none

// Testbench for the fully associative LRU key/value cache.
//
// The sender side drives command words with the start/busy handshake, changing the
// inputs on the falling clock edge. Every accepted word runs through a cycle-free
// LRU predictor that keeps its own copy of the keys, values, valid bits, recency
// ranks, fill count and capacity register. Each accepted word gives exactly one
// result word, so the expected result (typed or predicted) is queued at the accepting
// edge and the monitor pops it when the strobed result word appears.
module tb;
    import lkvc_pkg::*;

    localparam int unsigned DEPTH       = 16;
    localparam int unsigned NUM_PHASES  = 11;
    localparam int unsigned PHASE_WORDS = 158;
    localparam int unsigned POOL_SIZE   = 24;

    // Directed rows either write the capacity register or send one command word.
    typedef enum logic {ROW_WORD, ROW_CFG} row_kind_t;

    typedef struct packed {
        row_kind_t         kind;
        logic [CAP_W-1:0]  cap;
        in_word_t          cmd;
        logic              typed;  // expected result is written into the row itself
        out_word_t         want;
    } plan_row_t;

    logic                clk;
    logic                rst_n;
    logic                start;
    logic                busy;
    in_word_t            in_word;
    logic                cfg_we;
    logic [CAP_W-1:0]    cfg_wdata;
    logic                result_valid;
    out_word_t           result;

    // Predictor state.
    logic signed [WORD_W-1:0] lru_key   [DEPTH];
    logic signed [WORD_W-1:0] lru_value [DEPTH];
    logic                     lru_valid [DEPTH];
    logic [3:0]               lru_rank  [DEPTH];
    int unsigned              lru_fill;
    logic [CAP_W-1:0]         lru_capacity;

    // Result words that are still on their way through the cache, oldest first.
    out_word_t                pending_results [$];
    int unsigned              error_count;

    logic signed [WORD_W-1:0] key_pool [POOL_SIZE];

    // The directed part. Rows with a typed expectation can be read off directly: the
    // cache starts empty with capacity 16, so early lookups miss and early writes insert.
    // The remaining rows cover a capacity lowered below the fill count, a capacity of
    // zero that acts as one, a capacity above the entry count that saturates, and a
    // lookup whose value field must be ignored; the predictor decides those.
    localparam int unsigned PLAN_ROWS = 20;
    plan_row_t plan [PLAN_ROWS] = '{
        '{ROW_WORD, 5'd0, '{OP_LOOKUP, 32'sh0000_0000, 32'sh0000_0000},
          1'b1, '{1'b0, MISS_VALUE, 1'b0, 32'sh0}},
        '{ROW_WORD, 5'd0, '{OP_LOOKUP, 32'sh8000_0000, 32'sh0000_0000},
          1'b1, '{1'b0, MISS_VALUE, 1'b0, 32'sh0}},
        '{ROW_WORD, 5'd0, '{OP_WRITE, 32'sh7FFF_FFFF, 32'sh8000_0000},
          1'b1, '{1'b0, 32'sh8000_0000, 1'b0, 32'sh0}},
        '{ROW_WORD, 5'd0, '{OP_LOOKUP, 32'sh7FFF_FFFF, 32'sh0000_0000},
          1'b1, '{1'b1, 32'sh8000_0000, 1'b0, 32'sh0}},
        '{ROW_WORD, 5'd0, '{OP_WRITE, 32'sh8000_0000, 32'sh7FFF_FFFF},
          1'b1, '{1'b0, 32'sh7FFF_FFFF, 1'b0, 32'sh0}},
        '{ROW_WORD, 5'd0, '{OP_WRITE, 32'sh8000_0000, 32'shFFFF_FFFF},
          1'b1, '{1'b1, 32'shFFFF_FFFF, 1'b0, 32'sh0}},
        '{ROW_WORD, 5'd0, '{OP_LOOKUP, 32'sh8000_0000, 32'sh0000_0000},
          1'b1, '{1'b1, 32'shFFFF_FFFF, 1'b0, 32'sh0}},
        '{ROW_WORD, 5'd0, '{OP_WRITE, 32'sh0000_0000, 32'sh0000_0000},
          1'b1, '{1'b0, 32'sh0, 1'b0, 32'sh0}},
        '{ROW_CFG, 5'd1, '{OP_LOOKUP, 32'sh0, 32'sh0}, 1'b0, '0},
        '{ROW_WORD, 5'd0, '{OP_WRITE, 32'sh0000_0005, 32'sh5555_5555}, 1'b0, '0},
        '{ROW_WORD, 5'd0, '{OP_LOOKUP, 32'sh7FFF_FFFF, 32'sh0000_0000}, 1'b0, '0},
        '{ROW_WORD, 5'd0, '{OP_WRITE, 32'sh0000_0000, 32'shAAAA_AAAA}, 1'b0, '0},
        '{ROW_CFG, 5'd0, '{OP_LOOKUP, 32'sh0, 32'sh0}, 1'b0, '0},
        '{ROW_WORD, 5'd0, '{OP_WRITE, 32'shFFFF_FFFF, 32'sh1234_5678}, 1'b0, '0},
        '{ROW_WORD, 5'd0, '{OP_LOOKUP, 32'shFFFF_FFFF, 32'shDEAD_BEEF}, 1'b0, '0},
        '{ROW_CFG, 5'd31, '{OP_LOOKUP, 32'sh0, 32'sh0}, 1'b0, '0},
        '{ROW_WORD, 5'd0, '{OP_WRITE, 32'sh0000_0001, 32'sh0000_0001}, 1'b0, '0},
        '{ROW_WORD, 5'd0, '{OP_WRITE, 32'sh0000_0002, 32'sh0000_0002}, 1'b0, '0},
        '{ROW_WORD, 5'd0, '{OP_LOOKUP, 32'sh0000_0000, 32'sh0000_0000}, 1'b0, '0},
        '{ROW_CFG, 5'd16, '{OP_LOOKUP, 32'sh0, 32'sh0}, 1'b0, '0}
    };

    // Capacity used by each random phase; zero, one, the full depth and the largest
    // register value are all among them.
    logic [CAP_W-1:0] phase_capacity [NUM_PHASES] = '{
        5'd1, 5'd16, 5'd2, 5'd0, 5'd31, 5'd5, 5'd3, 5'd16, 5'd8, 5'd1, 5'd12
    };

    lru_key_value_cache #(
        .MAX_ENTRIES (DEPTH)
    ) u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .in_word      (in_word),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .result_valid (result_valid),
        .result       (result)
    );

    always #5 clk = ~clk;

    // Capacity as the cache applies it: zero acts as one, values above the depth saturate.
    function automatic int unsigned usable_capacity();
        if (lru_capacity == '0)
            return 1;
        if (lru_capacity > DEPTH)
            return DEPTH;
        return lru_capacity;
    endfunction

    // Entry idx becomes most recent; every valid entry that was more recent ages by one.
    function automatic void make_most_recent(int idx);
        logic [3:0] old_rank;
        old_rank = lru_rank[idx];
        for (int j = 0; j < DEPTH; j++)
            if (lru_valid[j] && lru_rank[j] < old_rank)
                lru_rank[j] = lru_rank[j] + 4'd1;
        lru_rank[idx] = 4'd0;
    endfunction

    // Applies one command word to the predictor state and returns its result word.
    function automatic out_word_t lru_predict(in_word_t cmd);
        out_word_t res;
        int        found;
        int        slot;
        res   = '0;
        found = -1;
        slot  = -1;
        for (int i = 0; i < DEPTH; i++)
            if (found < 0 && lru_valid[i] && lru_key[i] == cmd.key)
                found = i;

        if (cmd.operation == OP_LOOKUP)
        begin
            if (found >= 0)
            begin
                res.hit        = 1'b1;
                res.data_value = lru_value[found];
                make_most_recent(found);
            end
            else
            begin
                res.data_value = MISS_VALUE;
            end
        end
        else
        begin
            res.data_value = cmd.value;
            if (found >= 0)
            begin
                res.hit          = 1'b1;
                lru_value[found] = cmd.value;
                make_most_recent(found);
            end
            else
            begin
                // A new key: when the cache is full, the oldest valid entry goes first.
                // A capacity lowered below the fill count still evicts only one entry.
                if (lru_fill >= usable_capacity() && lru_fill > 0)
                begin
                    for (int i = 0; i < DEPTH; i++)
                    begin
                        if (!res.evicted && lru_valid[i] && lru_rank[i] == lru_fill - 1)
                        begin
                            res.evicted     = 1'b1;
                            res.evicted_key = lru_key[i];
                            lru_valid[i]    = 1'b0;
                            lru_fill--;
                        end
                    end
                end
                for (int i = 0; i < DEPTH; i++)
                    if (slot < 0 && !lru_valid[i])
                        slot = i;
                if (slot >= 0)
                begin
                    for (int i = 0; i < DEPTH; i++)
                        if (lru_valid[i])
                            lru_rank[i] = lru_rank[i] + 4'd1;
                    lru_key[slot]   = cmd.key;
                    lru_value[slot] = cmd.value;
                    lru_valid[slot] = 1'b1;
                    lru_rank[slot]  = 4'd0;
                    lru_fill++;
                end
            end
        end
        return res;
    endfunction

    // Presents one word and holds it until the cache takes it. The word is accepted at
    // the first rising edge that sees busy low. Start stays high afterwards; the caller
    // either presents the next word or lowers start at the following falling edge, so
    // start never gets two assignments in one time step.
    task automatic send_word(in_word_t cmd, logic typed, out_word_t want);
        out_word_t predicted;
        @(negedge clk);
        start   <= 1'b1;
        in_word <= cmd;
        do
            @(posedge clk);
        while (busy);
        predicted = lru_predict(cmd);
        pending_results.push_back(typed ? want : predicted);
    endtask

    // Sender gap with start low, its length set by the cycles argument.
    task automatic sender_idle(int unsigned cycles);
        @(negedge clk);
        start <= 1'b0;
        repeat (cycles) @(negedge clk);
    endtask

    // The capacity register is only written while the cache is idle: all results are
    // in and the rank update sweep that may follow the last result has finished.
    task automatic write_capacity(logic [CAP_W-1:0] cap);
        @(negedge clk);
        start <= 1'b0;
        while (pending_results.size() != 0 || busy)
            @(posedge clk);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= cap;
        @(negedge clk);
        cfg_we    <= 1'b0;
        lru_capacity = cap;
    endtask

    // Result monitor. The receiver cannot hold results off, so every strobe is a word.
    always @(posedge clk)
    begin
        out_word_t want;
        if (rst_n && result_valid)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: result word with nothing expected: actual %h", $time, result);
                error_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (result.hit !== want.hit)
                begin
                    $display("%0t: hit mismatch: expected %b actual %b",
                             $time, want.hit, result.hit);
                    error_count++;
                end
                if (result.data_value !== want.data_value)
                begin
                    $display("%0t: data_value mismatch: expected %h actual %h",
                             $time, want.data_value, result.data_value);
                    error_count++;
                end
                if (result.evicted !== want.evicted)
                begin
                    $display("%0t: evicted mismatch: expected %b actual %b",
                             $time, want.evicted, result.evicted);
                    error_count++;
                end
                if (result.evicted_key !== want.evicted_key)
                begin
                    $display("%0t: evicted_key mismatch: expected %h actual %h",
                             $time, want.evicted_key, result.evicted_key);
                    error_count++;
                end
            end
        end
    end

    // Main stimulus: reset, the directed table, then random phases at varied capacities.
    initial
    begin
        in_word_t    cmd;
        int unsigned pool_span;
        int unsigned idle_chance;
        clk          = 1'b0;
        rst_n        = 1'b0;
        start        = 1'b0;
        in_word      = '0;
        cfg_we       = 1'b0;
        cfg_wdata    = '0;
        error_count  = 0;
        lru_fill     = 0;
        lru_capacity = CAP_RESET;
        for (int i = 0; i < DEPTH; i++)
        begin
            lru_key[i]   = '0;
            lru_value[i] = '0;
            lru_valid[i] = 1'b0;
            lru_rank[i]  = '0;
        end

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (plan[r])
        begin
            if (plan[r].kind == ROW_CFG)
                write_capacity(plan[r].cap);
            else
                send_word(plan[r].cmd, plan[r].typed, plan[r].want);
        end

        // Random phases. Most keys come from a small pool a little larger than the
        // capacity, so that hits, updates of present keys and evictions are all common;
        // the rest are fully random keys that almost always miss. Each phase starts by
        // draining the cache and writing a new capacity.
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            write_capacity(phase_capacity[p]);
            pool_span = usable_capacity() + $urandom_range(1, 6);
            if (pool_span > POOL_SIZE)
                pool_span = POOL_SIZE;
            foreach (key_pool[k])
                key_pool[k] = $urandom;
            if ($urandom_range(0, 1) == 0)
            begin
                key_pool[0] = 32'sh8000_0000;
                key_pool[1] = 32'sh7FFF_FFFF;
            end
            // Some phases run without gaps; the last phase never idles.
            idle_chance = (p % 3 == 1 || p == NUM_PHASES - 1) ? 0 : $urandom_range(5, 20);
            for (int n = 0; n < PHASE_WORDS; n++)
            begin
                cmd.operation = $urandom_range(0, 1) ? OP_WRITE : OP_LOOKUP;
                cmd.key       = ($urandom_range(0, 99) < 85)
                              ? key_pool[$urandom_range(0, pool_span - 1)] : $urandom;
                cmd.value     = $urandom;
                send_word(cmd, 1'b0, '0);
                if (idle_chance != 0 && $urandom_range(0, 99) < idle_chance)
                    sender_idle($urandom_range(1, 19));
            end
        end

        @(negedge clk);
        start <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        // Let the last rank update sweep finish and catch any stray result strobe.
        repeat (2 * DEPTH + 8) @(posedge clk);

        if (error_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // Watchdog: far beyond the slowest correct run of about 1750 words.
    initial
    begin
        #5_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule

`default_nettype wire

@@ sim.f @@
+incdir+hw/rtl
hw/rtl/lkvc_pkg.sv
hw/rtl/lkvc_ram.sv
hw/rtl/lkvc_ctrl.sv
hw/rtl/lkvc_datapath.sv
hw/rtl/lru_key_value_cache.sv
verif/tb.sv
